// File: hw/rtl/tblim_pkg.sv
// ----------------------------------------------------------------------------
// tblim_pkg
// Shared widths, register indexes, reset values and the command bundle of the
// token bucket log limiter.
// ----------------------------------------------------------------------------
package tblim_pkg;

  localparam int MAX_TOKENS_W = 8;
  localparam int WINDOW_W     = 16;
  localparam int WARN_W       = 32;
  localparam int TIME_W       = 32;
  localparam int CFG_W        = 32;
  localparam int CFG_IDX_W    = 2;

  // product of capacity and elapsed time, also the dividend and the quotient
  localparam int PROD_W    = MAX_TOKENS_W + TIME_W;
  localparam int DIV_STEPS = PROD_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TOKENS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_WARN_MS    = CFG_IDX_W'(2);

  localparam logic [MAX_TOKENS_W-1:0] MAX_TOKENS_RST = MAX_TOKENS_W'(20);
  localparam logic [WINDOW_W-1:0]     WINDOW_MS_RST  = WINDOW_W'(1000);
  localparam logic [WARN_W-1:0]       WARN_MS_RST    = WARN_W'(1000);

  // controller to datapath
  typedef struct packed {
    logic load;      // capture the time stamp of a new transaction
    logic mul;       // form capacity times elapsed time
    logic div_step;  // one restoring division step
    logic commit;    // update bucket and drop state, load the result register
  } cmd_t;

endpackage

// File: hw/rtl/tblim_ctrl.sv
// ----------------------------------------------------------------------------
// tblim_ctrl
// Sequencer: accept a request, run the multiply and the bit-serial divide,
// then commit once the result register is free.
// ----------------------------------------------------------------------------
module tblim_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tblim_pkg::cmd_t   cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_COMMIT
  } state_e;

  state_e                          state_q;
  logic [tblim_pkg::STEP_W-1:0]    step_q;
  logic                            out_valid_q;
  logic                            out_busy;
  logic                            accept;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  // a result still waiting on the output blocks the commit
  assign out_busy = out_valid_q && !out_ready_i;

  assign in_ready_o       = (state_q == ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign cmd_o.load       = accept;
  assign cmd_o.mul        = (state_q == ST_MUL);
  assign cmd_o.div_step   = (state_q == ST_DIV);
  assign cmd_o.commit     = (state_q == ST_COMMIT) && !out_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // a commit refills the result register in the cycle the old one leaves
      if (cmd_o.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          step_q  <= tblim_pkg::STEP_W'(tblim_pkg::DIV_STEPS - 1);
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (step_q == '0) begin
            state_q <= ST_COMMIT;
          end else begin
            step_q <= step_q - 1'b1;
          end
        end
        ST_COMMIT: begin
          if (!out_busy) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/tblim_dp.sv
// ----------------------------------------------------------------------------
// tblim_dp
// Datapath: configuration registers, refill multiply, restoring divider,
// bucket and drop state, and the result register.
// ----------------------------------------------------------------------------
module tblim_dp #(
  parameter int TOKEN_WIDTH = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [tblim_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tblim_pkg::CFG_W-1:0]        cfg_data_i,
  input  tblim_pkg::cmd_t                    cmd_i,
  input  logic [tblim_pkg::TIME_W-1:0]       now_ms_i,
  output logic                               accepted_o,
  output logic                               report_due_o,
  output logic [tblim_pkg::TIME_W-1:0]       dropped_count_o,
  output logic [tblim_pkg::TIME_W-1:0]       report_span_ms_o
);

  localparam int PW  = tblim_pkg::PROD_W;
  localparam int TW  = tblim_pkg::TIME_W;
  localparam int WW  = tblim_pkg::WINDOW_W;
  localparam int MW  = tblim_pkg::MAX_TOKENS_W;
  localparam int SW  = PW + 1;
  localparam int CW  = (TOKEN_WIDTH > MW) ? TOKEN_WIDTH : MW;
  localparam logic [CW-1:0] TOKEN_FULL = CW'((64'd1 << TOKEN_WIDTH) - 64'd1);

  logic [MW-1:0]          max_tokens_q;
  logic [WW-1:0]          window_ms_q;
  logic [TW-1:0]          warn_ms_q;

  logic [TOKEN_WIDTH-1:0] tokens_q;
  logic [TW-1:0]          last_refill_q;
  logic [TW-1:0]          drop_cnt_q;
  logic [TW-1:0]          first_drop_q;

  logic [TW-1:0]          now_q;
  logic [PW-1:0]          prod_q;
  logic [WW-1:0]          rem_q;

  // divider step
  logic [WW-1:0]          divisor;
  logic [WW:0]            trial;
  logic                   trial_ge;
  logic [WW:0]            trial_sub;

  // commit logic
  logic [TW-1:0]          elapsed;
  logic [PW-1:0]          product;
  logic [CW-1:0]          cap;
  logic [SW-1:0]          sum;
  logic [SW-1:0]          cap_ext;
  logic                   refill;
  logic [TOKEN_WIDTH-1:0] tok_fill;
  logic                   take;
  logic [TW-1:0]          drop_span;
  logic                   report;

  assign divisor   = (window_ms_q == '0) ? WW'(1) : window_ms_q;
  assign trial     = {rem_q, prod_q[PW-1]};
  assign trial_ge  = (trial >= {1'b0, divisor});
  assign trial_sub = trial - {1'b0, divisor};

  assign elapsed = now_q - last_refill_q;
  assign product = {{TW{1'b0}}, max_tokens_q} * {{MW{1'b0}}, elapsed};

  assign cap     = (CW'(max_tokens_q) < TOKEN_FULL) ? CW'(max_tokens_q) : TOKEN_FULL;
  assign cap_ext = {{(SW-CW){1'b0}}, cap};
  // after the divide prod_q holds the number of new tokens
  assign sum      = {{(SW-TOKEN_WIDTH){1'b0}}, tokens_q} + {1'b0, prod_q};
  assign refill   = (prod_q != '0);
  assign tok_fill = refill ? ((sum < cap_ext) ? sum[TOKEN_WIDTH-1:0]
                                              : cap[TOKEN_WIDTH-1:0])
                           : tokens_q;
  assign take      = (tok_fill != '0);
  assign drop_span = now_q - first_drop_q;
  assign report    = take && (drop_cnt_q != '0) && (drop_span > warn_ms_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_tokens_q <= tblim_pkg::MAX_TOKENS_RST;
      window_ms_q  <= tblim_pkg::WINDOW_MS_RST;
      warn_ms_q    <= tblim_pkg::WARN_MS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tblim_pkg::CFG_MAX_TOKENS: max_tokens_q <= cfg_data_i[MW-1:0];
        tblim_pkg::CFG_WINDOW_MS:  window_ms_q  <= cfg_data_i[WW-1:0];
        tblim_pkg::CFG_WARN_MS:    warn_ms_q    <= cfg_data_i[TW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tokens_q      <= '0;
      last_refill_q <= '0;
      drop_cnt_q    <= '0;
      first_drop_q  <= '0;
    end else if (cmd_i.commit) begin
      tokens_q <= take ? tok_fill - 1'b1 : tok_fill;
      if (refill) begin
        last_refill_q <= now_q;
      end
      if (!take) begin
        if (drop_cnt_q == '0) begin
          first_drop_q <= now_q;
        end
        if (drop_cnt_q != '1) begin
          drop_cnt_q <= drop_cnt_q + 1'b1;
        end
      end else if (report) begin
        drop_cnt_q   <= '0;
        first_drop_q <= now_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      now_q <= now_ms_i;
    end
    if (cmd_i.mul) begin
      prod_q <= product;
      rem_q  <= '0;
    end else if (cmd_i.div_step) begin
      rem_q  <= trial_ge ? trial_sub[WW-1:0] : trial[WW-1:0];
      prod_q <= {prod_q[PW-2:0], trial_ge};
    end
    if (cmd_i.commit) begin
      accepted_o       <= take;
      report_due_o     <= report;
      dropped_count_o  <= report ? drop_cnt_q : '0;
      report_span_ms_o <= report ? drop_span : '0;
    end
  end

endmodule

// File: hw/rtl/token_bucket_log_limiter.sv
// ----------------------------------------------------------------------------
// token_bucket_log_limiter
// Token bucket limiter for log messages with saturating drop count reporting.
// ----------------------------------------------------------------------------
//
//  channel   handshake                 payload
//  -------   -----------------------   ------------------------------------
//  cfg       cfg_we_i                  cfg_idx_i, cfg_data_i
//  in        in_valid_i / in_ready_o   now_ms_i
//  out       out_valid_o / out_ready_i accepted_o, report_due_o,
//                                      dropped_count_o, report_span_ms_o
//
//  A transaction runs from acceptance through the multiply of capacity and
//  elapsed time, then the restoring divider of that product by window_ms
//  (one quotient bit per cycle), then the commit that loads the result. The
//  next request is taken only once the sequencer is back in idle.
//  in_ready_o is high only while the sequencer is idle; a new request may be
//  taken while the previous result waits on the output.
//  A stalled output holds the commit of the next request, no state changes.
//  Reset restores the configuration defaults and clears the bucket.
//
module token_bucket_log_limiter #(
  parameter int TOKEN_WIDTH = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [tblim_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tblim_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [tblim_pkg::TIME_W-1:0]       now_ms_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               accepted_o,
  output logic                               report_due_o,
  output logic [tblim_pkg::TIME_W-1:0]       dropped_count_o,
  output logic [tblim_pkg::TIME_W-1:0]       report_span_ms_o
);

  tblim_pkg::cmd_t cmd;

  tblim_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  tblim_dp #(
    .TOKEN_WIDTH (TOKEN_WIDTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .cmd_i            (cmd),
    .now_ms_i         (now_ms_i),
    .accepted_o       (accepted_o),
    .report_due_o     (report_due_o),
    .dropped_count_o  (dropped_count_o),
    .report_span_ms_o (report_span_ms_o)
  );

endmodule

// File: hw/rtl/tblim_checker.sv
// ----------------------------------------------------------------------------
// tblim_checker
// Port-level checks of the token bucket log limiter, bound to the top level.
// ----------------------------------------------------------------------------
module tblim_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic                          accepted_o,
  input logic                          report_due_o,
  input logic [tblim_pkg::TIME_W-1:0]  dropped_count_o,
  input logic [tblim_pkg::TIME_W-1:0]  report_span_ms_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(accepted_o)
      && $stable(report_due_o) && $stable(dropped_count_o)
      && $stable(report_span_ms_o))
    else $error("result changed while stalled");

  // busy right after a transaction is taken
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready high right after acceptance");

  // reports only ride on passed messages
  a_report_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && report_due_o |-> accepted_o && dropped_count_o != '0)
    else $error("report without a passed message or without drops");

  a_no_report_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !report_due_o |-> dropped_count_o == '0
      && report_span_ms_o == '0)
    else $error("report fields nonzero without a report");

endmodule

bind token_bucket_log_limiter tblim_checker u_tblim_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .accepted_o       (accepted_o),
  .report_due_o     (report_due_o),
  .dropped_count_o  (dropped_count_o),
  .report_span_ms_o (report_span_ms_o)
);
